@@ rtl/key_debounce_autorepeat_top_assert.svh @@
// assertion macros for the key debounce block
`ifndef KEY_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kda assertion failed");

// next-cycle implication, checked outside reset
`define KDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kda assertion failed");

`endif

@@ rtl/kda_pkg.sv @@
package kda_pkg;

  localparam int NumKeysDef    = 8;
  localparam int FilterBitsDef = 2;

  localparam int CmdW    = 2;
  localparam int KeyW    = 3;
  localparam int CodeW   = 3;
  localparam int RegW    = 8;
  localparam int ModeW   = 4;
  localparam int CfgIdxW = 2;
  // wide enough to compare a key index against a key count up to 127
  localparam int KeyCmpW = 7;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_START = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RATE_STEP    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_LENGTH = 2'd3;

  localparam logic [RegW-1:0] LONG_DELAY_RST   = 8'd32;
  localparam logic [RegW-1:0] REPEAT_START_RST = 8'd40;
  localparam logic [RegW-1:0] RATE_STEP_RST    = 8'd48;
  localparam logic [RegW-1:0] PAUSE_LENGTH_RST = 8'd64;

  // commands
  localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdW-1:0] CMD_PAUSE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_KILL   = 2'd2;

  // key modes; repeating is MODE_RPT plus the interval exponent
  localparam logic [ModeW-1:0] MODE_OFF    = 4'd0;
  localparam logic [ModeW-1:0] MODE_START  = 4'd1;
  localparam logic [ModeW-1:0] MODE_DELAY  = 4'd2;
  localparam logic [ModeW-1:0] MODE_PAUSE  = 4'd3;
  localparam logic [ModeW-1:0] MODE_KILLED = 4'd4;
  localparam logic [ModeW-1:0] MODE_RPT    = 4'd8;
  localparam logic [2:0]       RPT_EXP_MAX   = 3'd4;
  localparam logic [2:0]       RPT_EXP_PAUSE = 3'd3;

  // event codes
  localparam logic [CodeW-1:0] EV_NONE    = 3'd0;
  localparam logic [CodeW-1:0] EV_FIRST   = 3'd1;
  localparam logic [CodeW-1:0] EV_LONG    = 3'd2;
  localparam logic [CodeW-1:0] EV_REPEAT  = 3'd3;
  localparam logic [CodeW-1:0] EV_RELEASE = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key_index;
    logic            level;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0]  event_key;
    logic [CodeW-1:0] event_code;
  } result_t;

  typedef struct packed {
    logic [RegW-1:0] long_delay;
    logic [RegW-1:0] repeat_start;
    logic [RegW-1:0] rate_step;
    logic [RegW-1:0] pause_length;
  } cfg_t;

endpackage

@@ rtl/kda_cfg_regs.sv @@
module kda_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kda_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kda_pkg::RegW-1:0]     cfg_data_i,
  output kda_pkg::cfg_t                cfg_o
);

  kda_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_delay   <= kda_pkg::LONG_DELAY_RST;
      cfg_q.repeat_start <= kda_pkg::REPEAT_START_RST;
      cfg_q.rate_step    <= kda_pkg::RATE_STEP_RST;
      cfg_q.pause_length <= kda_pkg::PAUSE_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kda_pkg::CFG_LONG_DELAY:   cfg_q.long_delay   <= cfg_data_i;
        kda_pkg::CFG_REPEAT_START: cfg_q.repeat_start <= cfg_data_i;
        kda_pkg::CFG_RATE_STEP:    cfg_q.rate_step    <= cfg_data_i;
        kda_pkg::CFG_PAUSE_LENGTH: cfg_q.pause_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/kda_key_engine.sv @@
module kda_key_engine #(
  parameter int NUM_KEYS_P  = kda_pkg::NumKeysDef,
  parameter int FILTER_BITS = kda_pkg::FilterBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kda_pkg::cfg_t    cfg_i,
  input  kda_pkg::item_t   item_i,
  input  logic             commit_i,
  output kda_pkg::result_t result_o
);

  localparam int KeyIdxW = (NUM_KEYS_P > 1) ? $clog2(NUM_KEYS_P) : 1;

  logic [FILTER_BITS-1:0]    hist_q [NUM_KEYS_P];
  logic [kda_pkg::RegW-1:0]  cnt_q  [NUM_KEYS_P];
  logic [kda_pkg::ModeW-1:0] mode_q [NUM_KEYS_P];

  logic [kda_pkg::KeyCmpW-1:0] key_ext;
  logic [KeyIdxW-1:0]          idx;
  logic                        in_range;

  logic [FILTER_BITS-1:0]    hist_d;
  logic [kda_pkg::RegW-1:0]  cnt_d;
  logic [kda_pkg::ModeW-1:0] mode_d;
  logic [kda_pkg::CodeW-1:0] ev;

  assign key_ext  = kda_pkg::KeyCmpW'(item_i.key_index);
  assign idx      = key_ext[KeyIdxW-1:0];
  assign in_range = key_ext < kda_pkg::KeyCmpW'(NUM_KEYS_P);

  always_comb begin
    logic [FILTER_BITS:0]      shifted;
    logic [FILTER_BITS-1:0]    hist;
    logic [kda_pkg::RegW-1:0]  cnt;
    logic [kda_pkg::ModeW-1:0] mode;
    logic [2:0]                e;
    logic [kda_pkg::RegW-1:0]  rep_mask;

    shifted  = {hist_q[idx], item_i.level};
    hist     = shifted[FILTER_BITS-1:0];
    cnt      = cnt_q[idx] + 8'd1;
    mode     = mode_q[idx];
    ev       = kda_pkg::EV_NONE;
    e        = mode[2:0];
    rep_mask = '0;

    hist_d = hist_q[idx];
    cnt_d  = cnt_q[idx];
    mode_d = mode_q[idx];

    case (item_i.cmd)
      kda_pkg::CMD_SAMPLE: begin
        // release check runs ahead of the mode logic
        if (mode != kda_pkg::MODE_OFF && hist == '0) begin
          if (mode != kda_pkg::MODE_KILLED) ev = kda_pkg::EV_RELEASE;
          cnt  = '0;
          mode = kda_pkg::MODE_OFF;
        end

        if (mode == kda_pkg::MODE_START) begin
          ev   = kda_pkg::EV_FIRST;
          mode = kda_pkg::MODE_DELAY;
          cnt  = '0;
        end else if (mode == kda_pkg::MODE_DELAY) begin
          if (cnt == cfg_i.long_delay) ev = kda_pkg::EV_LONG;
          if (cnt == cfg_i.repeat_start) begin
            mode = {1'b1, kda_pkg::RPT_EXP_MAX};
            cnt  = '0;
          end
        end else if (mode[3] && mode[2:0] <= kda_pkg::RPT_EXP_MAX) begin
          e = mode[2:0];
          // speed up once the current rate has run its course
          if (e != 3'd0 && cnt >= cfg_i.rate_step) begin
            e    = e - 3'd1;
            mode = {1'b1, e};
            cnt  = '0;
          end
          rep_mask = ~(8'hFF << e);
          if ((cnt & rep_mask) == '0) ev = kda_pkg::EV_REPEAT;
        end else if (mode == kda_pkg::MODE_PAUSE) begin
          if (cnt >= cfg_i.pause_length) begin
            mode = {1'b1, kda_pkg::RPT_EXP_PAUSE};
            cnt  = '0;
          end
        end else if (mode == kda_pkg::MODE_KILLED) begin
          // silent until released
        end else begin
          mode = kda_pkg::MODE_OFF;
          if (hist == '1) begin
            mode = kda_pkg::MODE_START;
            cnt  = '0;
          end
        end

        hist_d = hist;
        cnt_d  = cnt;
        mode_d = mode;
      end
      kda_pkg::CMD_PAUSE: begin
        mode_d = kda_pkg::MODE_PAUSE;
        cnt_d  = '0;
      end
      kda_pkg::CMD_KILL: begin
        mode_d = kda_pkg::MODE_KILLED;
      end
      default: ;
    endcase

    if (!in_range) ev = kda_pkg::EV_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS_P; k++) begin
        hist_q[k] <= '0;
        cnt_q[k]  <= '0;
        mode_q[k] <= kda_pkg::MODE_OFF;
      end
    end else if (commit_i && in_range) begin
      hist_q[idx] <= hist_d;
      cnt_q[idx]  <= cnt_d;
      mode_q[idx] <= mode_d;
    end
  end

  assign result_o.event_code = ev;
  assign result_o.event_key  = (ev == kda_pkg::EV_NONE) ? '0 : item_i.key_index;

endmodule

@@ rtl/kda_out_reg.sv @@
module kda_out_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  kda_pkg::result_t            result_i,
  input  logic                        out_stall_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  output logic [kda_pkg::KeyW-1:0]    event_key_o,
  output logic [kda_pkg::CodeW-1:0]   event_code_o
);

  logic             valid_q;
  kda_pkg::result_t res_q;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign event_key_o  = res_q.event_key;
  assign event_code_o = res_q.event_code;

endmodule

@@ rtl/key_debounce_autorepeat_top.sv @@
// key debouncer with long press and accelerating auto-repeat
//
// input channel: in_valid_i / in_stall_o carry one item (cmd_i, key_index_i,
// level_i). an item is taken at a clock edge with valid high and stall low.
// output channel: out_valid_o / out_stall_i carry one result item
// (event_key_o, event_code_o); every input item gives exactly one result,
// code 0 when nothing happened
// configuration: cfg_we_i writes cfg_data_i into the register at cfg_index_i
// (0 long delay, 1 repeat start, 2 rate step, 3 pause length)
// path: a taken item waits in the input register, and its result is registered
// in the result register once that register can take it
// throughput: one item per cycle unless the result register stalls; each item is one
// read-modify-write of its key's history, counter and mode behind the input register
// stall: while the result register is full and stalled the input register
// holds, and in_stall_o rises once the input register is also occupied
// reset: all keys are released with cleared counters, registers take their
// defaults, both pipeline registers are empty
module key_debounce_autorepeat_top #(
  parameter int NUM_KEYS_P  = kda_pkg::NumKeysDef,
  parameter int FILTER_BITS = kda_pkg::FilterBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [kda_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kda_pkg::RegW-1:0]     cfg_data_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kda_pkg::CmdW-1:0]     cmd_i,
  input  logic [kda_pkg::KeyW-1:0]     key_index_i,
  input  logic                         level_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kda_pkg::KeyW-1:0]     event_key_o,
  output logic [kda_pkg::CodeW-1:0]    event_code_o
);

  kda_pkg::cfg_t    cfg;
  kda_pkg::item_t   item_q;
  kda_pkg::result_t result;

  logic s1_valid_q;
  logic s1_valid_d;
  logic out_ready;
  logic s1_adv;
  logic in_take;

  kda_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // item leaves the input register when the result register can take it
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_take || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd       <= cmd_i;
      item_q.key_index <= key_index_i;
      item_q.level     <= level_i;
    end
  end

  // key state is written back in the same cycle the result is registered,
  // so a following item for the same key sees the update
  kda_key_engine #(
    .NUM_KEYS_P  (NUM_KEYS_P),
    .FILTER_BITS (FILTER_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .commit_i (s1_adv),
    .result_o (result)
  );

  kda_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_adv),
    .result_i     (result),
    .out_stall_i  (out_stall_i),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .event_key_o  (event_key_o),
    .event_code_o (event_code_o)
  );

`include "key_debounce_autorepeat_top_assert.svh"

  // an empty event never names a key
  `KDA_ASSERT_NOW(a_none_has_zero_key,
    out_valid_o && event_code_o == kda_pkg::EV_NONE, event_key_o == '0)
  // only defined event codes leave the block
  `KDA_ASSERT_NOW(a_code_defined, out_valid_o, event_code_o <= kda_pkg::EV_RELEASE)
  // an item moving out of the input register always lands in the result register
  `KDA_ASSERT_NEXT(a_adv_lands, s1_adv, out_valid_o)
  // a stalled full result register keeps the input register occupied
  `KDA_ASSERT_NEXT(a_hold_when_blocked, s1_valid_q && out_valid_o && out_stall_i, s1_valid_q)

endmodule

@@ tb/key_debounce_autorepeat_top_tb.sv @@
module key_debounce_autorepeat_top_tb;
  import kda_pkg::*;

  localparam int NumKeys = NumKeysDef;
  localparam logic [RegW-1:0] HistMask = RegW'((1 << FilterBitsDef) - 1);
  // cmd code the block must ignore
  localparam logic [CmdW-1:0] CMD_UNKNOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RegW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CmdW-1:0]    cmd_i = '0;
  logic [KeyW-1:0]    key_index_i = '0;
  logic               level_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [KeyW-1:0]    event_key_o;
  logic [CodeW-1:0]   event_code_o;

  key_debounce_autorepeat_top #(
    .NUM_KEYS_P (NumKeysDef),
    .FILTER_BITS(FilterBitsDef)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_index_i (key_index_i),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_key_o (event_key_o),
    .event_code_o(event_code_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and the per-key state
  logic [RegW-1:0]  long_delay_q   = LONG_DELAY_RST;
  logic [RegW-1:0]  repeat_start_q = REPEAT_START_RST;
  logic [RegW-1:0]  rate_step_q    = RATE_STEP_RST;
  logic [RegW-1:0]  pause_length_q = PAUSE_LENGTH_RST;
  logic [RegW-1:0]  hist_q [NumKeys] = '{default: '0};
  logic [RegW-1:0]  tick_q [NumKeys] = '{default: '0};
  logic [ModeW-1:0] mode_q [NumKeys] = '{default: MODE_OFF};

  item_t   key_items[$];
  result_t expected_events[$];
  item_t   next_item;
  result_t want;
  bit      item_taken = 1'b0;
  bit      quiet = 1'b0;
  bit      big_hold_done = 1'b0;
  int      items_in = 0;
  int      send_gap = 0;
  int      hold_left = 0;
  int      errors = 0;

  // advances one key by one item and returns the event it gives
  function automatic result_t predict_event(logic [CmdW-1:0] cmd, logic [KeyW-1:0] k,
                                            logic lvl);
    logic [ModeW-1:0] mode;
    logic [RegW-1:0]  hist;
    logic [RegW-1:0]  cnt;
    logic [CodeW-1:0] ev;
    int               e;
    result_t          r;
    ev = EV_NONE;
    if (int'(k) < NumKeys) begin
      case (cmd)
        CMD_SAMPLE: begin
          mode = mode_q[k];
          hist = ((hist_q[k] << 1) | {{(RegW-1){1'b0}}, lvl}) & HistMask;
          cnt = tick_q[k] + 8'd1;
          hist_q[k] = hist;
          // release check first, silent for a killed key
          if (mode != MODE_OFF && hist == '0) begin
            if (mode != MODE_KILLED) ev = EV_RELEASE;
            cnt = '0;
            mode = MODE_OFF;
          end
          if (mode == MODE_START) begin
            ev = EV_FIRST;
            mode = MODE_DELAY;
            cnt = '0;
          end else if (mode == MODE_DELAY) begin
            if (cnt == long_delay_q) ev = EV_LONG;
            if (cnt == repeat_start_q) begin
              mode = MODE_RPT + RPT_EXP_MAX;
              cnt = '0;
            end
          end else if (mode >= MODE_RPT && mode <= MODE_RPT + RPT_EXP_MAX) begin
            e = mode - MODE_RPT;
            // speed up: halve the interval after rate_step ticks
            if (e > 0 && cnt >= rate_step_q) begin
              e--;
              mode = MODE_RPT + ModeW'(e);
              cnt = '0;
            end
            if ((cnt & ((8'd1 << e) - 8'd1)) == '0) ev = EV_REPEAT;
          end else if (mode == MODE_PAUSE) begin
            if (cnt >= pause_length_q) begin
              mode = MODE_RPT + RPT_EXP_PAUSE;
              cnt = '0;
            end
          end else if (mode != MODE_KILLED) begin
            mode = MODE_OFF;
            if (hist == HistMask) begin
              mode = MODE_START;
              cnt = '0;
            end
          end
          tick_q[k] = cnt;
          mode_q[k] = mode;
        end
        CMD_PAUSE: begin
          mode_q[k] = MODE_PAUSE;
          tick_q[k] = '0;
        end
        CMD_KILL: mode_q[k] = MODE_KILLED;
        default: ;
      endcase
    end
    r.event_key = (ev == EV_NONE) ? '0 : k;
    r.event_code = ev;
    return r;
  endfunction

  // input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk_i) begin
    item_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_events.push_back(predict_event(cmd_i, key_index_i, level_i));
      items_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got key %0d code %0d",
                 $time, event_key_o, event_code_o);
      end else begin
        want = expected_events.pop_front();
        if (event_key_o !== want.event_key) begin
          errors++;
          $display("%0t: event_key mismatch, expected %0d, got %0d",
                   $time, want.event_key, event_key_o);
        end
        if (event_code_o !== want.event_code) begin
          errors++;
          $display("%0t: event_code mismatch, expected %0d, got %0d",
                   $time, want.event_code, event_code_o);
        end
      end
    end
  end

  // sender: holds a stalled item, otherwise takes the next pending one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !item_taken) begin
      // blocked, payload stays
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (key_items.size() > 0) begin
      next_item = key_items.pop_front();
      cmd_i <= next_item.cmd;
      key_index_i <= next_item.key_index;
      level_i <= next_item.level;
      in_valid_i <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: short random stall bursts, one long hold to back up the pipe
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (!big_hold_done && items_in >= 150) begin
      big_hold_done = 1'b1;
      hold_left = 79;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_item(logic [CmdW-1:0] c, logic [KeyW-1:0] k, logic l);
    item_t it;
    it.cmd = c;
    it.key_index = k;
    it.level = l;
    key_items.push_back(it);
  endtask

  task automatic hold_key(logic [KeyW-1:0] k, int n);
    repeat (n) push_item(CMD_SAMPLE, k, 1'b1);
  endtask

  task automatic drop_key(logic [KeyW-1:0] k);
    repeat (2) push_item(CMD_SAMPLE, k, 1'b0);
  endtask

  task automatic wait_idle();
    while (key_items.size() != 0 || expected_events.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [RegW-1:0] ld, logic [RegW-1:0] rs,
                            logic [RegW-1:0] st, logic [RegW-1:0] pl);
    logic [CfgIdxW-1:0] idx_list [4];
    logic [RegW-1:0]    vals [4];
    idx_list = '{CFG_LONG_DELAY, CFG_REPEAT_START, CFG_RATE_STEP, CFG_PAUSE_LENGTH};
    vals = '{ld, rs, st, pl};
    wait_idle();
    long_delay_q = ld;
    repeat_start_q = rs;
    rate_step_q = st;
    pause_length_q = pl;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i <= vals[i];
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  // press and release sessions on a few neighbouring keys, with glitches,
  // pause and kill commands and some noise on any key
  task automatic play_keys(int n, int max_press, int spread, int ctl_odds);
    int press_left [NumKeys];
    int rel_left [NumKeys];
    bit fresh [NumKeys];
    int kbase;
    int k;
    int r;
    int made;
    foreach (press_left[i]) begin
      press_left[i] = 0;
      rel_left[i] = 0;
      fresh[i] = 1'b1;
    end
    kbase = $urandom_range(0, NumKeys - 1);
    made = 0;
    while (made < n) begin
      k = (kbase + $urandom_range(0, spread)) % NumKeys;
      if ($urandom_range(0, ctl_odds / 3) == 0) begin
        push_item(CmdW'($urandom_range(0, 3)), KeyW'($urandom_range(0, NumKeys - 1)),
                  1'($urandom_range(0, 1)));
        made++;
      end else if (press_left[k] > 0) begin
        r = $urandom_range(0, ctl_odds);
        if (r == 0) push_item(CMD_PAUSE, KeyW'(k), 1'($urandom_range(0, 1)));
        else if (r == 1) push_item(CMD_KILL, KeyW'(k), 1'($urandom_range(0, 1)));
        else push_item(CMD_SAMPLE, KeyW'(k), $urandom_range(0, 24) != 0);
        press_left[k]--;
        made++;
      end else if (rel_left[k] > 0) begin
        push_item(CMD_SAMPLE, KeyW'(k), $urandom_range(0, 9) == 0);
        rel_left[k]--;
        made++;
      end else begin
        // first press of a key in a phase is the longest one
        if (fresh[k]) press_left[k] = max_press;
        else if ($urandom_range(0, 5) == 0) press_left[k] = $urandom_range(1, max_press);
        else press_left[k] = $urandom_range(1, max_press / 4 + 2);
        fresh[k] = 1'b0;
        rel_left[k] = $urandom_range(2, 4);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first press, pause, kill with silent release
    hold_key(3'd0, 5);
    push_item(CMD_PAUSE, 3'd0, 1'b0);
    hold_key(3'd0, 2);
    push_item(CMD_KILL, 3'd0, 1'b1);
    drop_key(3'd0);
    // highest key: press then normal release
    hold_key(3'd7, 3);
    drop_key(3'd7);
    // unknown command is ignored
    push_item(CMD_UNKNOWN, 3'd5, 1'b1);
    push_item(CMD_UNKNOWN, 3'd2, 1'b0);
    // a bouncing level never counts as a press
    push_item(CMD_SAMPLE, 3'd3, 1'b1);
    push_item(CMD_SAMPLE, 3'd3, 1'b0);
    push_item(CMD_SAMPLE, 3'd3, 1'b1);
    drop_key(3'd3);

    // defaults, long hold of the receiver falls in here
    play_keys(300, 260, 1, 200);
    // zero compares only match after the counter wraps, fastest rates
    set_config(8'd0, 8'd0, 8'd1, 8'd1);
    play_keys(400, 300, 0, 2000);
    // all registers at the top
    set_config(8'd255, 8'd255, 8'd255, 8'd255);
    play_keys(150, 60, 2, 60);
    // short delays reach every repeat rate quickly
    set_config(8'd3, 8'd5, 8'd4, 8'd3);
    play_keys(400, 50, 2, 60);
    // long press and repeat start on the same tick
    set_config(8'd6, 8'd6, 8'd2, 8'd2);
    play_keys(200, 40, 2, 60);
    // repeat starts before the long press count, no idling at the end
    set_config(8'd12, 8'd4, 8'd3, 8'd5);
    quiet = 1'b1;
    play_keys(200, 40, 2, 60);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
